// ===== rtl/core/bcm_pkg.sv =====
// Package for the six-step sensorless commutator: shared types, codes,
// the commutation step table and a divide-by-15 helper.
// No dependencies.
package bcm_pkg;

    // Request kinds carried on the input stream.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_ZC   = 2'd1;
    localparam logic [1:0] REQ_DUTY = 2'd2;

    // Event codes reported with each result.
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_COMM  = 3'd1;
    localparam logic [2:0] EV_STALL = 3'd2;
    localparam logic [2:0] EV_STOP  = 3'd3;
    localparam logic [2:0] EV_DONE  = 3'd4;

    // Mode codes as reported on the result stream.
    localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_CODE_START = 2'd1;
    localparam logic [1:0] MODE_CODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_CODE_HOLD  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_THR    = 3'd0;
    localparam logic [2:0] CFG_STOP_THR     = 3'd1;
    localparam logic [2:0] CFG_START_DUTY   = 3'd2;
    localparam logic [2:0] CFG_STALL_MS     = 3'd3;
    localparam logic [2:0] CFG_HOLDOFF_MS   = 3'd4;
    localparam logic [2:0] CFG_START_PERIOD = 3'd5;
    localparam logic [2:0] CFG_MIN_PERIOD   = 3'd6;
    localparam logic [2:0] CFG_SLEW_MS      = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Alignment dwell on step 0 before open-loop stepping, in ms.
    localparam logic [9:0] ALIGN_MS = 10'd5;

    // Reciprocal of 15 in 12 fractional bits; it never overestimates.
    localparam logic [8:0] RECIP_15  = 9'd273;
    localparam int         DIV_SHIFT = 12;

    // Motor sequencer state.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_mode;

    // Configuration registers as one group.
    typedef struct packed {
        logic [7:0] start_thr;
        logic [7:0] stop_thr;
        logic [7:0] start_duty;
        logic [7:0] stall_ms;
        logic [9:0] holdoff_ms;
        logic [8:0] start_period;
        logic [8:0] min_period;
        logic [3:0] slew_ms;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [1:0] phase_high;
        logic [1:0] phase_low;
        logic [1:0] sense_phase;
        logic       rising_edge;
        logic [7:0] high_duty;
        logic       drive_on;
        logic [1:0] mode;
        logic [7:0] duty_now;
        logic [2:0] event_res;
    } t_result;

    // One commutation step: high phase, low phase, sensed phase, polarity.
    typedef struct packed {
        logic [1:0] hi;
        logic [1:0] lo;
        logic [1:0] sense;
        logic       rising;
    } t_step_ent;

    function automatic t_step_ent step_lookup(input logic [2:0] step);
        t_step_ent e;
        case (step)
            3'd0:    e = '{hi: 2'd0, lo: 2'd1, sense: 2'd2, rising: 1'b0};
            3'd1:    e = '{hi: 2'd0, lo: 2'd2, sense: 2'd1, rising: 1'b1};
            3'd2:    e = '{hi: 2'd1, lo: 2'd2, sense: 2'd0, rising: 1'b0};
            3'd3:    e = '{hi: 2'd1, lo: 2'd0, sense: 2'd2, rising: 1'b1};
            3'd4:    e = '{hi: 2'd2, lo: 2'd0, sense: 2'd1, rising: 1'b0};
            3'd5:    e = '{hi: 2'd2, lo: 2'd1, sense: 2'd0, rising: 1'b1};
            default: e = '{hi: 2'd0, lo: 2'd1, sense: 2'd2, rising: 1'b0};
        endcase
        return e;
    endfunction

    // Mode state to its reported code.
    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            ST_IDLE:  c = MODE_CODE_IDLE;
            ST_START: c = MODE_CODE_START;
            ST_RUN:   c = MODE_CODE_RUN;
            ST_HOLD:  c = MODE_CODE_HOLD;
            default:  c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

    // Floor of x / 15: reciprocal multiply, then one correction step.
    function automatic logic [5:0] div15(input logic [8:0] x);
        logic [17:0] prod;
        logic [5:0]  q;
        logic [9:0]  qx15;
        logic [9:0]  rem;
        prod = {9'd0, x} * {9'd0, RECIP_15};
        q    = prod[17:DIV_SHIFT];
        qx15 = {4'd0, q} * 10'd15;
        rem  = {1'b0, x} - qx15;
        if (rem >= 10'd15) begin
            q = q + 6'd1;
        end
        return q;
    endfunction

endpackage

// ===== rtl/core/bcm_cfg_regs.sv =====
// Configuration register file of the commutator, write only.
// Depends on bcm_pkg for the register indexes and the t_cfg group.
module bcm_cfg_regs
    import bcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes, truncated to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_thr    <= 8'd30;
            r_cfg.stop_thr     <= 8'd20;
            r_cfg.start_duty   <= 8'd30;
            r_cfg.stall_ms     <= 8'd10;
            r_cfg.holdoff_ms   <= 10'd1000;
            r_cfg.start_period <= 9'd300;
            r_cfg.min_period   <= 9'd25;
            r_cfg.slew_ms      <= 4'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_THR:    r_cfg.start_thr    <= i_cfg_wdata[7:0];
                CFG_STOP_THR:     r_cfg.stop_thr     <= i_cfg_wdata[7:0];
                CFG_START_DUTY:   r_cfg.start_duty   <= i_cfg_wdata[7:0];
                CFG_STALL_MS:     r_cfg.stall_ms     <= i_cfg_wdata[7:0];
                CFG_HOLDOFF_MS:   r_cfg.holdoff_ms   <= i_cfg_wdata[9:0];
                CFG_START_PERIOD: r_cfg.start_period <= i_cfg_wdata[8:0];
                CFG_MIN_PERIOD:   r_cfg.min_period   <= i_cfg_wdata[8:0];
                CFG_SLEW_MS:      r_cfg.slew_ms      <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/bcm_seq.sv =====
// Commutation sequencer: motor state registers and their next-state logic,
// producing the result for the request presented this cycle.
// Depends on bcm_pkg.
module bcm_seq
    import bcm_pkg::*;
#(
    parameter int TICKS_PER_MS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_req,
    input  logic [7:0] i_duty,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int SW = $clog2(TICKS_PER_MS + 1);

    t_mode      r_mode,     n_mode;
    logic [2:0] r_step,     n_step;
    logic [7:0] r_duty_cur, n_duty_cur;
    logic [7:0] r_duty_set, n_duty_set;
    logic [7:0] r_duty_lat, n_duty_lat;
    logic       r_zc_en,    n_zc_en;
    logic       r_drv_en,   n_drv_en;
    logic       r_align,    n_align;
    logic [SW-1:0] r_sub_ms, n_sub_ms;
    logic [3:0] r_slot,     n_slot;
    logic [7:0] r_stall,    n_stall;
    logic [8:0] r_len,      n_len;
    logic [9:0] r_wait,     n_wait;

    logic [2:0]    ev;
    logic [SW-1:0] sub_inc;
    logic          sub_wrap;
    logic [9:0]    wait_dec;
    logic [8:0]    shrink;
    logic [8:0]    len_next;
    logic [7:0]    stall_dec;
    logic [4:0]    slot_inc;
    logic [7:0]    duty_slew;
    t_step_ent     ent;

    // Shared arithmetic for the tick paths.
    assign sub_inc   = r_sub_ms + SW'(1);
    assign sub_wrap  = (sub_inc >= SW'(TICKS_PER_MS));
    assign wait_dec  = (r_wait != 10'd0) ? (r_wait - 10'd1) : 10'd0;
    assign shrink    = {3'd0, div15(r_len)} + 9'd1;
    assign len_next  = (r_len > shrink) ? (r_len - shrink) : 9'd0;
    assign stall_dec = r_stall - 8'd1;
    assign slot_inc  = {1'b0, r_slot} + 5'd1;

    // Duty moves one count toward the set point.
    always_comb begin
        if (r_duty_cur < r_duty_set) begin
            duty_slew = r_duty_cur + 8'd1;
        end else if (r_duty_cur > r_duty_set) begin
            duty_slew = r_duty_cur - 8'd1;
        end else begin
            duty_slew = r_duty_cur;
        end
    end

    // Next state for one request.
    always_comb begin
        n_mode     = r_mode;
        n_step     = r_step;
        n_duty_cur = r_duty_cur;
        n_duty_set = r_duty_set;
        n_duty_lat = r_duty_lat;
        n_zc_en    = r_zc_en;
        n_drv_en   = r_drv_en;
        n_align    = r_align;
        n_sub_ms   = r_sub_ms;
        n_slot     = r_slot;
        n_stall    = r_stall;
        n_len      = r_len;
        n_wait     = r_wait;
        ev         = EV_NONE;

        case (i_req)
            REQ_TICK: begin
                if (r_mode == ST_START) begin
                    if (r_align) begin
                        // Alignment dwell counts whole milliseconds.
                        n_sub_ms = sub_wrap ? '0 : sub_inc;
                        if (sub_wrap) begin
                            n_wait = wait_dec;
                            if (wait_dec == 10'd0) begin
                                n_align = 1'b0;
                                n_len   = i_cfg.start_period;
                                n_wait  = {1'b0, i_cfg.start_period};
                            end
                        end
                    end else begin
                        // Open-loop stepping with a shrinking period.
                        n_wait = wait_dec;
                        if (wait_dec == 10'd0) begin
                            if (len_next < i_cfg.min_period) begin
                                n_mode     = ST_RUN;
                                n_zc_en    = 1'b1;
                                n_stall    = i_cfg.stall_ms;
                                n_duty_cur = i_cfg.start_duty;
                                n_sub_ms   = '0;
                                ev         = EV_DONE;
                            end else begin
                                n_len      = len_next;
                                n_wait     = {1'b0, len_next};
                                n_step     = (r_step < 3'd5) ? (r_step + 3'd1) : 3'd0;
                                n_duty_lat = r_duty_cur;
                                n_drv_en   = 1'b1;
                                ev         = EV_COMM;
                            end
                        end
                    end
                end else begin
                    n_sub_ms = sub_wrap ? '0 : sub_inc;
                    if (sub_wrap) begin
                        if (r_mode == ST_HOLD) begin
                            // Holdoff countdown back to idle.
                            if (r_wait != 10'd0) begin
                                n_wait = wait_dec;
                            end else begin
                                n_mode = ST_IDLE;
                            end
                        end else if (r_stall == 8'd1) begin
                            // Stall timeout: everything off, hold off restarts.
                            n_stall    = 8'd0;
                            n_duty_cur = 8'd0;
                            n_duty_lat = 8'd0;
                            n_drv_en   = 1'b0;
                            n_zc_en    = 1'b0;
                            n_duty_set = 8'd0;
                            n_mode     = ST_HOLD;
                            n_wait     = i_cfg.holdoff_ms;
                            ev         = EV_STALL;
                        end else begin
                            if (r_stall != 8'd0) begin
                                n_stall = stall_dec;
                            end
                            if (r_mode == ST_IDLE && r_duty_set >= i_cfg.start_thr) begin
                                // Start-up: align on step 0 at start duty.
                                n_mode     = ST_START;
                                n_zc_en    = 1'b0;
                                n_duty_cur = i_cfg.start_duty;
                                n_step     = 3'd0;
                                n_duty_lat = i_cfg.start_duty;
                                n_drv_en   = 1'b1;
                                n_align    = 1'b1;
                                n_wait     = ALIGN_MS;
                                n_sub_ms   = '0;
                                ev         = EV_COMM;
                            end else if (slot_inc >= {1'b0, i_cfg.slew_ms}) begin
                                // Slew slot; a low duty while running stops.
                                n_slot = 4'd0;
                                if (r_mode == ST_RUN) begin
                                    n_duty_cur = duty_slew;
                                    if (duty_slew < i_cfg.stop_thr) begin
                                        n_duty_cur = 8'd0;
                                        n_duty_lat = 8'd0;
                                        n_drv_en   = 1'b0;
                                        n_zc_en    = 1'b0;
                                        n_mode     = ST_IDLE;
                                        ev         = EV_STOP;
                                    end
                                end
                            end else begin
                                n_slot = slot_inc[3:0];
                            end
                        end
                    end
                end
            end
            REQ_ZC: begin
                // Closed-loop commutation on a zero-cross.
                if (r_zc_en && r_mode == ST_RUN) begin
                    n_step     = (r_step < 3'd5) ? (r_step + 3'd1) : 3'd0;
                    n_duty_lat = r_duty_cur;
                    n_drv_en   = 1'b1;
                    n_stall    = i_cfg.stall_ms;
                    ev         = EV_COMM;
                end
            end
            REQ_DUTY: begin
                n_duty_set = i_duty;
            end
            default: begin
            end
        endcase
    end

    // State registers, updated once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ST_IDLE;
            r_step     <= 3'd0;
            r_duty_cur <= 8'd0;
            r_duty_set <= 8'd0;
            r_duty_lat <= 8'd0;
            r_zc_en    <= 1'b0;
            r_drv_en   <= 1'b0;
            r_align    <= 1'b0;
            r_sub_ms   <= '0;
            r_slot     <= 4'd0;
            r_stall    <= 8'd0;
            r_len      <= 9'd0;
            r_wait     <= 10'd0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_step     <= n_step;
            r_duty_cur <= n_duty_cur;
            r_duty_set <= n_duty_set;
            r_duty_lat <= n_duty_lat;
            r_zc_en    <= n_zc_en;
            r_drv_en   <= n_drv_en;
            r_align    <= n_align;
            r_sub_ms   <= n_sub_ms;
            r_slot     <= n_slot;
            r_stall    <= n_stall;
            r_len      <= n_len;
            r_wait     <= n_wait;
        end
    end

    // Result fields reflect the state after this request.
    assign ent = step_lookup(n_step);

    always_comb begin
        o_result.phase_high  = ent.hi;
        o_result.phase_low   = ent.lo;
        o_result.sense_phase = ent.sense;
        o_result.rising_edge = ent.rising;
        o_result.high_duty   = n_duty_lat;
        o_result.drive_on    = n_drv_en;
        o_result.mode        = mode_code(n_mode);
        o_result.duty_now    = n_duty_cur;
        o_result.event_res   = ev;
    end

endmodule

// ===== rtl/core/sensorless_bldc_commutator.sv =====
// Top level of the six-step sensorless BLDC commutator: stream handshake,
// input and result registers. Uses bcm_pkg, bcm_cfg_regs and bcm_seq.
//
// Each request (tick, zero-cross or duty set point) yields exactly one
// result. The block takes one request per clock while the result sink keeps
// up: a request sits in the input register while the sequencer computes the
// new motor state in a single pass, and the result is written into the
// result register when the request advances, which back pressure can delay.
// The update loop through the sequencer state registers sets that rate. A new
// request is taken while a result waits for the sink, and back pressure
// stalls the input register only when both stages are full. Configuration
// writes take effect on the next clock; there is no clearing pass after
// reset.
module sensorless_bldc_commutator
    import bcm_pkg::*;
#(
    parameter int TICKS_PER_MS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] duty_value
    input  logic [1:0]            s_axis_tuser,   // [1:0] req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] phase_high, [3:2] phase_low, [5:4] sense_phase, [6] rising_edge,
    // [14:7] high_duty, [15] drive_on, [17:16] mode, [25:18] duty_now,
    // [28:26] event_res, [31:29] zero
    output logic [31:0]           m_axis_tdata
);

    t_cfg       cfg;
    t_result    result;
    logic       r_in_valid;
    logic [1:0] r_in_req;
    logic [7:0] r_in_duty;
    logic       r_out_valid;
    logic [31:0] r_out_data;
    logic       advance;

    bcm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bcm_seq #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_req    (r_in_req),
        .i_duty   (r_in_duty),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // The held request moves on when the result register is free.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req  <= s_axis_tuser;
            r_in_duty <= s_axis_tdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {3'd0, result.event_res, result.duty_now, result.mode,
                           result.drive_on, result.high_duty, result.rising_edge,
                           result.sense_phase, result.phase_low, result.phase_high};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/core/bcm_checker.sv =====
// Port-level checks for the commutator result stream, bound to the top.
// Depends on bcm_pkg for the event and mode codes.
module bcm_checker
    import bcm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // With the drive off no duty is latched onto the high side.
    a_off_no_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[15] |-> m_axis_tdata[14:7] == 8'd0)
        else $error("latched duty with drive off");

    // Idle and holdoff never drive the bridge.
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[17:16] == MODE_CODE_IDLE ||
                          m_axis_tdata[17:16] == MODE_CODE_HOLD)
        |-> !m_axis_tdata[15])
        else $error("drive on while idle or in holdoff");

    // A stall lands in holdoff with the duty cleared.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[28:26] == EV_STALL
        |-> m_axis_tdata[17:16] == MODE_CODE_HOLD && m_axis_tdata[25:18] == 8'd0)
        else $error("stall without holdoff");

endmodule

bind sensorless_bldc_commutator bcm_checker u_bcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/sensorless_bldc_commutator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sensorless_bldc_commutator: streams tick, zero-cross
// and set-point transfers and checks each status transfer against a behavioral
// model of the six-step sequencer. Depends on bcm_pkg and the commutator RTL.
module sensorless_bldc_commutator_tb;
    import bcm_pkg::*;

    localparam int         TICKS_PER_MS     = 20;
    localparam logic [1:0] REQ_NOP          = 2'd3;
    localparam logic [9:0] ALIGN_DWELL_MS   = 10'd5;
    localparam int         IDLE_LIMIT       = 2000;
    localparam int         SINK_HOLD_CYCLES = 400;
    localparam int         SINK_HOLD_AT     = 100;
    localparam int         MAX_REPORTS      = 10;
    localparam int         PHASE_COUNT      = 8;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] duty;
    } t_motor_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] duty_value
    logic [1:0]            s_axis_tuser = '0;   // [1:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] phase_high, [3:2] phase_low, [5:4] sense_phase, [6] rising_edge,
    // [14:7] high_duty, [15] drive_on, [17:16] mode, [25:18] duty_now, [28:26] event_res
    logic [31:0]           m_axis_tdata;

    // Stimulus and scoreboard bookkeeping.
    t_motor_cmd cmd_fifo[$];
    t_result    expected_status[$];
    logic       in_fire = 1'b0;
    int         accepted_in = 0;
    int         idle_cycles = 0;
    int         fail_count = 0;
    int         send_idle_pct = 0;
    int         sink_stall_pct = 0;
    int         sink_hold_left = 0;
    logic       sink_hold_done = 1'b0;

    // Shadow copy of the configuration registers, at their reset values.
    logic [7:0] cfg_start_thr    = 8'd30;
    logic [7:0] cfg_stop_thr     = 8'd20;
    logic [7:0] cfg_start_duty   = 8'd30;
    logic [7:0] cfg_stall_ms     = 8'd10;
    logic [9:0] cfg_holdoff_ms   = 10'd1000;
    logic [8:0] cfg_start_period = 9'd300;
    logic [8:0] cfg_min_period   = 9'd25;
    logic [3:0] cfg_slew_ms      = 4'd10;

    // Model state of the motor sequencer, at its reset values.
    logic [2:0] m_step = '0;
    logic [7:0] m_duty = '0;
    logic [7:0] m_duty_target = '0;
    logic [7:0] m_duty_latched = '0;
    logic [1:0] m_mode = MODE_CODE_IDLE;
    logic       m_zc_armed = 1'b0;
    logic       m_drive = 1'b0;
    logic       m_aligning = 1'b0;
    logic [4:0] m_tick_div = '0;
    logic [3:0] m_slot = '0;
    logic [7:0] m_stall_left = '0;
    logic [8:0] m_step_len = '0;
    logic [9:0] m_wait = '0;

    sensorless_bldc_commutator #(
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Commutation table row as {rising, sense, low, high}.
    function automatic logic [6:0] step_row(input logic [2:0] step);
        case (step)
            3'd1:    return {1'b1, 2'd1, 2'd2, 2'd0};
            3'd2:    return {1'b0, 2'd0, 2'd2, 2'd1};
            3'd3:    return {1'b1, 2'd2, 2'd0, 2'd1};
            3'd4:    return {1'b0, 2'd1, 2'd0, 2'd2};
            3'd5:    return {1'b1, 2'd0, 2'd1, 2'd2};
            default: return {1'b0, 2'd2, 2'd1, 2'd0};
        endcase
    endfunction

    function automatic void latch_drive();
        m_duty_latched = m_duty;
        m_drive        = 1'b1;
    endfunction

    function automatic void next_step();
        m_step = (m_step < 3'd5) ? m_step + 3'd1 : 3'd0;
        latch_drive();
    endfunction

    function automatic void cut_drive();
        m_duty         = '0;
        m_duty_latched = '0;
        m_drive        = 1'b0;
        m_zc_armed     = 1'b0;
    endfunction

    // One tick during start-up: alignment dwell, then shrinking open-loop steps.
    function automatic logic [2:0] open_loop_tick();
        int len, dec;
        if (m_aligning) begin
            m_tick_div = m_tick_div + 5'd1;
            if (m_tick_div >= TICKS_PER_MS) begin
                m_tick_div = '0;
                if (m_wait != 0) m_wait = m_wait - 10'd1;
                if (m_wait == 0) begin
                    m_aligning = 1'b0;
                    m_step_len = cfg_start_period;
                    m_wait     = {1'b0, cfg_start_period};
                end
            end
            return EV_NONE;
        end
        if (m_wait != 0) m_wait = m_wait - 10'd1;
        if (m_wait != 0) return EV_NONE;
        len = int'(m_step_len);
        dec = len / 15 + 1;
        len = (len > dec) ? len - dec : 0;
        if (len < cfg_min_period) begin
            m_mode       = MODE_CODE_RUN;
            m_zc_armed   = 1'b1;
            m_stall_left = cfg_stall_ms;
            m_duty       = cfg_start_duty;
            m_tick_div   = '0;
            return EV_DONE;
        end
        m_step_len = len[8:0];
        m_wait     = len[9:0];
        next_step();
        return EV_COMM;
    endfunction

    // Millisecond boundary: holdoff, stall countdown, start check, duty slew.
    function automatic logic [2:0] ms_boundary_step();
        if (m_mode == MODE_CODE_HOLD) begin
            if (m_wait != 0) begin
                m_wait = m_wait - 10'd1;
            end else begin
                m_mode = MODE_CODE_IDLE;
            end
            return EV_NONE;
        end
        if (m_stall_left != 0) begin
            m_stall_left = m_stall_left - 8'd1;
            if (m_stall_left == 0) begin
                cut_drive();
                m_duty_target = '0;
                m_mode        = MODE_CODE_HOLD;
                m_wait        = cfg_holdoff_ms;
                return EV_STALL;
            end
        end
        if (m_mode == MODE_CODE_IDLE && m_duty_target >= cfg_start_thr) begin
            m_mode     = MODE_CODE_START;
            m_zc_armed = 1'b0;
            m_duty     = cfg_start_duty;
            m_step     = '0;
            latch_drive();
            m_aligning = 1'b1;
            m_wait     = ALIGN_DWELL_MS;
            m_tick_div = '0;
            return EV_COMM;
        end
        m_slot = m_slot + 4'd1;
        if (m_slot >= cfg_slew_ms) begin
            m_slot = '0;
            if (m_mode == MODE_CODE_RUN) begin
                if (m_duty < m_duty_target) m_duty = m_duty + 8'd1;
                if (m_duty > m_duty_target) m_duty = m_duty - 8'd1;
                if (m_duty < cfg_stop_thr) begin
                    cut_drive();
                    m_mode = MODE_CODE_IDLE;
                    return EV_STOP;
                end
            end
        end
        return EV_NONE;
    endfunction

    // Applies one request to the model and returns the status it produces.
    function automatic t_result predict_status(input t_motor_cmd c);
        logic [2:0] ev;
        logic [6:0] row;
        t_result    r;
        ev = EV_NONE;
        if (c.req == REQ_TICK) begin
            if (m_mode == MODE_CODE_START) begin
                ev = open_loop_tick();
            end else begin
                m_tick_div = m_tick_div + 5'd1;
                if (m_tick_div >= TICKS_PER_MS) begin
                    m_tick_div = '0;
                    ev = ms_boundary_step();
                end
            end
        end else if (c.req == REQ_ZC) begin
            if (m_zc_armed && m_mode == MODE_CODE_RUN) begin
                next_step();
                m_stall_left = cfg_stall_ms;
                ev = EV_COMM;
            end
        end else if (c.req == REQ_DUTY) begin
            m_duty_target = c.duty;
        end
        row           = step_row(m_step);
        r.phase_high  = row[1:0];
        r.phase_low   = row[3:2];
        r.sense_phase = row[5:4];
        r.rising_edge = row[6];
        r.high_duty   = m_duty_latched;
        r.drive_on    = m_drive;
        r.mode        = m_mode;
        r.duty_now    = m_duty;
        r.event_res   = ev;
        return r;
    endfunction

    function automatic string status_text(input t_result s);
        return $sformatf({"hi=%0d lo=%0d sense=%0d rise=%0b hduty=%0d",
                          " drive=%0b mode=%0d duty=%0d ev=%0d"},
                         s.phase_high, s.phase_low, s.sense_phase, s.rising_edge,
                         s.high_duty, s.drive_on, s.mode, s.duty_now, s.event_res);
    endfunction

    // Scoreboard: predicts on each request transfer, checks each status transfer,
    // and ends the run when nothing moves for too long.
    always @(posedge i_clk) begin : scoreboard
        logic       out_fire;
        t_result    got;
        t_result    want;
        t_motor_cmd cmd;
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire) begin
            cmd.req  = s_axis_tuser;
            cmd.duty = s_axis_tdata;
            expected_status.push_back(predict_status(cmd));
            accepted_in++;
        end
        if (out_fire) begin
            got.phase_high  = m_axis_tdata[1:0];
            got.phase_low   = m_axis_tdata[3:2];
            got.sense_phase = m_axis_tdata[5:4];
            got.rising_edge = m_axis_tdata[6];
            got.high_duty   = m_axis_tdata[14:7];
            got.drive_on    = m_axis_tdata[15];
            got.mode        = m_axis_tdata[17:16];
            got.duty_now    = m_axis_tdata[25:18];
            got.event_res   = m_axis_tdata[28:26];
            if (expected_status.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("Unexpected status transfer: %s", status_text(got));
                end
            end else begin
                want = expected_status.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("Status mismatch after %0d requests", accepted_in);
                        $display("  expected %s", status_text(want));
                        $display("  actual   %s", status_text(got));
                    end
                end
            end
        end
        if (in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Request driver: offers the next queued request when the slot is free.
    always @(negedge i_clk) begin : request_driver
        t_motor_cmd c;
        if (!s_axis_tvalid || in_fire) begin
            if (cmd_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                c = cmd_fifo.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= c.req;
                s_axis_tdata  <= c.duty;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Status sink: random stalls, plus one long hold-off that backs up the block.
    always @(negedge i_clk) begin
        if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
            m_axis_tready  <= 1'b0;
        end else if (!sink_hold_done && accepted_in >= SINK_HOLD_AT) begin
            sink_hold_done <= 1'b1;
            sink_hold_left <= SINK_HOLD_CYCLES;
            m_axis_tready  <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic void push_cmd(input logic [1:0] req, input logic [7:0] duty);
        t_motor_cmd c;
        c.req  = req;
        c.duty = duty;
        cmd_fifo.push_back(c);
    endfunction

    // Set points cluster around the start and stop thresholds, with some
    // fully random values and the extremes.
    function automatic logic [7:0] pick_set_point();
        int lo, hi, roll;
        roll = $urandom_range(99);
        if (roll < 25) return 8'($urandom_range(255));
        if (roll < 32) return 8'd0;
        if (roll < 40) return 8'd255;
        lo = int'(cfg_stop_thr) - 3;
        hi = int'(cfg_start_thr) + 30;
        if (lo < 0) lo = 0;
        if (hi > 255) hi = 255;
        return 8'($urandom_range(hi, lo));
    endfunction

    // Mostly well-formed stretches: running with regular zero-crosses,
    // silent stretches that let start-up, stall and holdoff play out,
    // set-point changes, and a little noise with every request code.
    task automatic build_phase(input int n_items);
        int added, kind, len, gap, k;
        added = 0;
        while (added < n_items) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                len = $urandom_range(60, 15);
                gap = $urandom_range(12, 2);
                for (k = 1; k <= len; k++) begin
                    push_cmd((k % gap == 0) ? REQ_ZC : REQ_TICK, 8'($urandom));
                end
                added += len;
            end else if (kind < 70) begin
                len = $urandom_range(120, 20);
                repeat (len) push_cmd(REQ_TICK, 8'($urandom));
                added += len;
            end else if (kind < 90) begin
                push_cmd(REQ_DUTY, pick_set_point());
                added++;
            end else begin
                len = $urandom_range(5, 1);
                repeat (len) push_cmd(2'($urandom_range(3)), 8'($urandom));
                added += len;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_START_THR:    cfg_start_thr    = value[7:0];
            CFG_STOP_THR:     cfg_stop_thr     = value[7:0];
            CFG_START_DUTY:   cfg_start_duty   = value[7:0];
            CFG_STALL_MS:     cfg_stall_ms     = value[7:0];
            CFG_HOLDOFF_MS:   cfg_holdoff_ms   = value[9:0];
            CFG_START_PERIOD: cfg_start_period = value[8:0];
            CFG_MIN_PERIOD:   cfg_min_period   = value[8:0];
            CFG_SLEW_MS:      cfg_slew_ms      = value[3:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input int st_thr, input int sp_thr, input int st_duty,
                                 input int stall, input int hold, input int period,
                                 input int min_period, input int slew);
        write_reg(CFG_START_THR, st_thr);
        write_reg(CFG_STOP_THR, sp_thr);
        write_reg(CFG_START_DUTY, st_duty);
        write_reg(CFG_STALL_MS, stall);
        write_reg(CFG_HOLDOFF_MS, hold);
        write_reg(CFG_START_PERIOD, period);
        write_reg(CFG_MIN_PERIOD, min_period);
        write_reg(CFG_SLEW_MS, slew);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued request has been taken and every status has come.
    task automatic wait_drained();
        @(negedge i_clk);
        while (cmd_fifo.size() != 0 || s_axis_tvalid || expected_status.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at reset settings: every request code, field
        // extremes, an ignored zero-cross, and a start at exactly the threshold.
        push_cmd(REQ_TICK, 8'hFF);
        push_cmd(REQ_ZC, 8'h00);
        push_cmd(REQ_DUTY, 8'hFF);
        push_cmd(REQ_NOP, 8'hA5);
        push_cmd(REQ_DUTY, 8'd29);
        push_cmd(REQ_DUTY, 8'd30);
        repeat (TICKS_PER_MS - 1) push_cmd(REQ_TICK, 8'h5A);
        wait_drained();

        // Random phases, each with its own settings; the idling pattern cycles through four kinds.
        for (int ph = 1; ph <= PHASE_COUNT; ph++) begin
            case (ph)
                1: load_settings(40, 20, 60, 3, 2, 12, 6, 1);
                2: load_settings(0, 255, 255, 1, 0, 0, 1, 0);
                3: load_settings(60, 30, 90, 2, 1, 20, 15, 2);
                4: load_settings(255, 0, 0, 255, 1023, 511, 511, 15);
                5: load_settings(30, 25, 35, 4, 3, 9, 3, 3);
                6: load_settings(45, 10, 200, 2, 0, 5, 5, 5);
                7: load_settings(20, 15, 25, 1, 1, 1, 1, 1);
                default: load_settings(35, 20, 40, 3, 2, 15, 4, 2);
            endcase
            case ((ph - 1) % 4)
                0: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 73;
                    sink_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 73;
                end
                default: begin
                    send_idle_pct  = 30;
                    sink_stall_pct = 30;
                end
            endcase
            build_phase((ph == 4) ? 150 : 240);
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && expected_status.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bcm_pkg.sv
rtl/core/bcm_cfg_regs.sv
rtl/core/bcm_seq.sv
rtl/core/sensorless_bldc_commutator.sv
rtl/core/bcm_checker.sv
tb/sv/sensorless_bldc_commutator_tb.sv
